[hw/rtl/slt_pkg.sv]
// Shared types, constants and keyword table of the script lexer.
package slt_pkg;

  localparam int CH_W    = 8;
  localparam int KIND_W  = 6;
  localparam int START_W = 32;
  localparam int LEN_W   = 16;
  localparam int LINE_W  = 24;

  localparam int DEF_KEYWORD_CHARS     = 8;
  localparam int DEF_MAX_COMMENT_DEPTH = 255;
  localparam int DEF_OFFSET_BITS       = 32;

  localparam int KW_COUNT = 22;
  localparam int KW_CHARS = 8;

  // token kinds
  localparam logic [KIND_W-1:0] K_LPAREN   = 6'd0;
  localparam logic [KIND_W-1:0] K_RPAREN   = 6'd1;
  localparam logic [KIND_W-1:0] K_LBRACE   = 6'd2;
  localparam logic [KIND_W-1:0] K_RBRACE   = 6'd3;
  localparam logic [KIND_W-1:0] K_SEMI     = 6'd4;
  localparam logic [KIND_W-1:0] K_COMMA    = 6'd5;
  localparam logic [KIND_W-1:0] K_DOT      = 6'd6;
  localparam logic [KIND_W-1:0] K_QUEST    = 6'd7;
  localparam logic [KIND_W-1:0] K_COLON    = 6'd8;
  localparam logic [KIND_W-1:0] K_MINUS    = 6'd9;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd11;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd13;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd15;
  localparam logic [KIND_W-1:0] K_SLASH_EQ = 6'd16;
  localparam logic [KIND_W-1:0] K_BANG     = 6'd17;
  localparam logic [KIND_W-1:0] K_EQUAL    = 6'd19;
  localparam logic [KIND_W-1:0] K_LESS     = 6'd21;
  localparam logic [KIND_W-1:0] K_GREATER  = 6'd23;
  localparam logic [KIND_W-1:0] K_IDENT    = 6'd25;
  localparam logic [KIND_W-1:0] K_STRING   = 6'd26;
  localparam logic [KIND_W-1:0] K_NUMBER   = 6'd27;
  localparam logic [KIND_W-1:0] K_KW_BASE  = 6'd28;
  localparam logic [KIND_W-1:0] K_ERR_STR  = 6'd50;
  localparam logic [KIND_W-1:0] K_ERR_CHAR = 6'd51;
  localparam logic [KIND_W-1:0] K_EOF      = 6'd52;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start_offset;
    logic [LEN_W-1:0]   lexeme_length;
    logic [LINE_W-1:0]  line_number;
    logic               last;
  } token_t;

  // keyword text, first character in the most significant used byte
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "and", "break", "case", "class", "continue", "default", "else", "false",
    "for", "fun", "if", "let", "nil", "or", "print", "return", "super",
    "switch", "this", "true", "var", "while"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd4, 4'd5, 4'd8, 4'd7, 4'd4, 4'd5,
    4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd2, 4'd5, 4'd6, 4'd5,
    4'd6, 4'd4, 4'd4, 4'd3, 4'd5
  };

  // pfx[8*i +: 8] holds character i of the identifier
  function automatic logic [KIND_W-1:0] kw_lookup(input logic [8*KW_CHARS-1:0] pfx,
                                                  input logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] res;
    logic              hit;
    int                n;
    res = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      n   = int'(KW_LEN[k]);
      hit = (len == LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS; i++) begin
        if (i < n && pfx[8*i +: 8] != KW_TEXT[k][8*(n-1-i) +: 8]) hit = 1'b0;
      end
      if (hit) res = K_KW_BASE + KIND_W'(k);
    end
    return res;
  endfunction

endpackage

[hw/rtl/slt_if.sv]
// Channel interfaces: source bytes in, tokens out.
interface slt_byte_if;
  logic                     valid;
  logic                     ready;
  logic [slt_pkg::CH_W-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface slt_tok_if;
  logic                        valid;
  logic                        ready;
  logic [slt_pkg::KIND_W-1:0]  kind;
  logic [slt_pkg::START_W-1:0] start_offset;
  logic [slt_pkg::LEN_W-1:0]   lexeme_length;
  logic [slt_pkg::LINE_W-1:0]  line_number;
  logic                        last;
  modport source (output valid, output kind, output start_offset, output lexeme_length,
                  output line_number, output last, input ready);
  modport sink   (input valid, input kind, input start_offset, input lexeme_length,
                  input line_number, input last, output ready);
endinterface

[hw/rtl/script_lexer_tokenizer.sv]
// Streaming tokenizer: one source byte in, zero to three tokens out.
//
//  channel | dir | payload                                        | transaction
//  --------+-----+------------------------------------------------+-----------------
//  src     | in  | ch (8b, 0 = end of input)                      | one source byte
//  tok     | out | kind, start_offset, lexeme_length, line_number,| one token
//          |     | last                                           |
//
// A byte is scanned in the cycle it is taken; its tokens land in an 8-entry
// token queue that drains one token per cycle while tok.ready is high. src.ready
// is high while the queue has room for three tokens, so bytes stream at one per
// cycle as long as the token side keeps up. Synchronous active-high reset returns
// the scanner to idle at line 1, offset 0, and empties the queue. A byte 0 also
// returns the scanner to its reset state after its tokens are queued.
module script_lexer_tokenizer #(
  parameter int KEYWORD_CHARS     = slt_pkg::DEF_KEYWORD_CHARS,
  parameter int MAX_COMMENT_DEPTH = slt_pkg::DEF_MAX_COMMENT_DEPTH,
  parameter int OFFSET_BITS       = slt_pkg::DEF_OFFSET_BITS
) (
  input logic clk,
  input logic rst,
  slt_byte_if.sink  src,
  slt_tok_if.source tok
);

  localparam int DW  = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam int QD  = 8;
  localparam int QAW = 3;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_OP2, M_IDENT, M_NUM, M_NUMDOT, M_FRAC, M_STRING
  } mode_t;

  // scanner state
  mode_t                              scan_mode,    scan_mode_next;
  logic [OFFSET_BITS-1:0]             lexeme_start, lexeme_start_next;
  logic [OFFSET_BITS-1:0]             position,     position_next;
  logic [slt_pkg::LINE_W-1:0]         line_count,   line_count_next;
  logic [slt_pkg::LEN_W-1:0]          run_length,   run_length_next;
  logic [KEYWORD_CHARS-1:0][7:0]      prefix_chars, prefix_chars_next;
  logic [DW-1:0]                      comment_depth, comment_depth_next;
  logic [7:0]                         held_char,    held_char_next;

  // tokens made by this byte
  slt_pkg::token_t                    res [3];
  logic [1:0]                         res_n;

  // token queue
  slt_pkg::token_t                    q_mem [QD];
  logic [QAW-1:0]                     q_wr, q_rd;
  logic [QAW:0]                       q_cnt;

  logic [7:0] c;
  logic       take, pop;

  assign c    = src.ch;
  assign take = src.valid && src.ready;
  assign pop  = tok.valid && tok.ready;
  assign src.ready = (q_cnt <= (QAW+1)'(QD - 3));

  function automatic logic is_alpha(input logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic [slt_pkg::KIND_W-1:0] op_single(input logic [7:0] x);
    logic [slt_pkg::KIND_W-1:0] k;
    case (x)
      "-":     k = slt_pkg::K_MINUS;
      "+":     k = slt_pkg::K_PLUS;
      "*":     k = slt_pkg::K_STAR;
      "!":     k = slt_pkg::K_BANG;
      "=":     k = slt_pkg::K_EQUAL;
      "<":     k = slt_pkg::K_LESS;
      default: k = slt_pkg::K_GREATER;
    endcase
    return k;
  endfunction

  function automatic logic [slt_pkg::LEN_W-1:0] sat_add(input logic [slt_pkg::LEN_W-1:0] a,
                                                        input logic [1:0] k);
    logic [slt_pkg::LEN_W:0] s;
    s = {1'b0, a} + (slt_pkg::LEN_W+1)'(k);
    return s[slt_pkg::LEN_W] ? '1 : s[slt_pkg::LEN_W-1:0];
  endfunction

  // scan step
  always_comb begin
    logic [slt_pkg::LINE_W-1:0]        line_up;
    logic [8*slt_pkg::KW_CHARS-1:0]    pfx;
    logic                              again;
    logic [slt_pkg::KIND_W-1:0]        ek [3];
    logic [OFFSET_BITS-1:0]            es [3];
    logic [slt_pkg::LEN_W-1:0]         el [3];
    logic [1:0]                        n;

    line_up = (line_count == '1) ? line_count : line_count + 1'b1;
    for (int i = 0; i < slt_pkg::KW_CHARS; i++) pfx[8*i +: 8] = prefix_chars[i];

    scan_mode_next     = scan_mode;
    lexeme_start_next  = lexeme_start;
    line_count_next    = line_count;
    run_length_next    = run_length;
    prefix_chars_next  = prefix_chars;
    comment_depth_next = comment_depth;
    held_char_next     = held_char;
    again              = 1'b0;
    n                  = 2'd0;
    for (int i = 0; i < 3; i++) begin
      ek[i] = '0;
      es[i] = '0;
      el[i] = '0;
    end

    unique case (scan_mode)
      M_SLASH: begin
        if (c == "/") scan_mode_next = M_LINE;
        else if (c == "*") begin
          scan_mode_next     = M_BLOCK;
          comment_depth_next = DW'(1);
          held_char_next     = '0;
        end else if (c == "=") begin
          ek[n] = slt_pkg::K_SLASH_EQ; es[n] = lexeme_start; el[n] = 16'd2; n = n + 1'b1;
          scan_mode_next = M_IDLE;
        end else begin
          ek[n] = slt_pkg::K_SLASH; es[n] = lexeme_start; el[n] = 16'd1; n = n + 1'b1;
          again = 1'b1;
        end
      end
      M_LINE: begin
        if (c == 8'h0A) begin
          line_count_next = line_up;
          scan_mode_next  = M_IDLE;
        end else if (c == 8'h00) again = 1'b1;
      end
      M_BLOCK: begin
        if (c == 8'h00) again = 1'b1;
        else if (held_char == "*" && c == "/") begin
          held_char_next     = '0;
          comment_depth_next = comment_depth - 1'b1;
          if (comment_depth == DW'(1)) scan_mode_next = M_IDLE;
        end else if (held_char == "/" && c == "*") begin
          held_char_next = '0;
          if (comment_depth < DW'(MAX_COMMENT_DEPTH)) comment_depth_next = comment_depth + 1'b1;
        end else begin
          held_char_next = (c == "*" || c == "/") ? c : 8'h00;
          if (c == 8'h0A) line_count_next = line_up;
        end
      end
      M_OP2: begin
        if (c == "=") begin
          ek[n] = op_single(held_char) + 1'b1; es[n] = lexeme_start; el[n] = 16'd2;
          n = n + 1'b1;
          scan_mode_next = M_IDLE;
        end else begin
          ek[n] = op_single(held_char); es[n] = lexeme_start; el[n] = 16'd1; n = n + 1'b1;
          again = 1'b1;
        end
        held_char_next = '0;
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          for (int i = 0; i < KEYWORD_CHARS; i++)
            if (run_length == slt_pkg::LEN_W'(i)) prefix_chars_next[i] = c;
          run_length_next = sat_add(run_length, 2'd1);
        end else begin
          ek[n] = slt_pkg::kw_lookup(pfx, run_length); es[n] = lexeme_start;
          el[n] = run_length; n = n + 1'b1;
          again = 1'b1;
        end
      end
      M_NUM, M_FRAC: begin
        if (is_digit(c)) run_length_next = sat_add(run_length, 2'd1);
        else if (c == "." && scan_mode == M_NUM) scan_mode_next = M_NUMDOT;
        else begin
          ek[n] = slt_pkg::K_NUMBER; es[n] = lexeme_start; el[n] = run_length; n = n + 1'b1;
          again = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (is_digit(c)) begin
          run_length_next = sat_add(run_length, 2'd2);
          scan_mode_next  = M_FRAC;
        end else begin
          ek[n] = slt_pkg::K_NUMBER; es[n] = lexeme_start; el[n] = run_length; n = n + 1'b1;
          ek[n] = slt_pkg::K_DOT; es[n] = position - 1'b1; el[n] = 16'd1; n = n + 1'b1;
          again = 1'b1;
        end
      end
      M_STRING: begin
        if (c == "\"") begin
          ek[n] = slt_pkg::K_STRING; es[n] = lexeme_start;
          el[n] = sat_add(run_length, 2'd1); n = n + 1'b1;
          run_length_next = sat_add(run_length, 2'd1);
          scan_mode_next  = M_IDLE;
        end else if (c == 8'h00) begin
          ek[n] = slt_pkg::K_ERR_STR; es[n] = lexeme_start; el[n] = run_length; n = n + 1'b1;
          again = 1'b1;
        end else begin
          if (c == 8'h0A) line_count_next = line_up;
          run_length_next = sat_add(run_length, 2'd1);
        end
      end
      default: again = 1'b1;
    endcase

    // between tokens: start whatever this byte opens
    if (again) begin
      scan_mode_next    = M_IDLE;
      lexeme_start_next = position;
      case (c)
        8'h00: begin
          ek[n] = slt_pkg::K_EOF; es[n] = position; el[n] = 16'd0; n = n + 1'b1;
        end
        " ", 8'h0D, 8'h09: ;
        8'h0A: line_count_next = line_up;
        "(", ")", "{", "}", ";", ",", ".", "?", ":": begin
          case (c)
            "(":     ek[n] = slt_pkg::K_LPAREN;
            ")":     ek[n] = slt_pkg::K_RPAREN;
            "{":     ek[n] = slt_pkg::K_LBRACE;
            "}":     ek[n] = slt_pkg::K_RBRACE;
            ";":     ek[n] = slt_pkg::K_SEMI;
            ",":     ek[n] = slt_pkg::K_COMMA;
            ".":     ek[n] = slt_pkg::K_DOT;
            "?":     ek[n] = slt_pkg::K_QUEST;
            default: ek[n] = slt_pkg::K_COLON;
          endcase
          es[n] = position; el[n] = 16'd1; n = n + 1'b1;
        end
        "/": scan_mode_next = M_SLASH;
        "-", "+", "*", "!", "=", "<", ">": begin
          held_char_next = c;
          scan_mode_next = M_OP2;
        end
        "\"": begin
          run_length_next = 16'd1;
          scan_mode_next  = M_STRING;
        end
        default: begin
          if (is_alpha(c)) begin
            prefix_chars_next    = '0;
            prefix_chars_next[0] = c;
            run_length_next      = 16'd1;
            scan_mode_next       = M_IDENT;
          end else if (is_digit(c)) begin
            run_length_next = 16'd1;
            scan_mode_next  = M_NUM;
          end else begin
            ek[n] = slt_pkg::K_ERR_CHAR; es[n] = position; el[n] = 16'd1; n = n + 1'b1;
          end
        end
      endcase
    end

    if (c == 8'h00) begin
      scan_mode_next     = M_IDLE;
      lexeme_start_next  = '0;
      position_next      = '0;
      line_count_next    = slt_pkg::LINE_W'(1);
      run_length_next    = '0;
      prefix_chars_next  = '0;
      comment_depth_next = '0;
      held_char_next     = '0;
    end else begin
      position_next = position + 1'b1;
    end

    res_n = n;
    for (int i = 0; i < 3; i++) begin
      res[i].kind          = ek[i];
      res[i].start_offset  = slt_pkg::START_W'(es[i]);
      res[i].lexeme_length = el[i];
      res[i].line_number   = line_count;
      res[i].last          = (2'(i + 1) == n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= M_IDLE;
      lexeme_start  <= '0;
      position      <= '0;
      line_count    <= slt_pkg::LINE_W'(1);
      run_length    <= '0;
      prefix_chars  <= '0;
      comment_depth <= '0;
      held_char     <= '0;
    end else if (take) begin
      scan_mode     <= scan_mode_next;
      lexeme_start  <= lexeme_start_next;
      position      <= position_next;
      line_count    <= line_count_next;
      run_length    <= run_length_next;
      prefix_chars  <= prefix_chars_next;
      comment_depth <= comment_depth_next;
      held_char     <= held_char_next;
    end
  end

  // token queue: up to three pushes and, while tok.ready is high, one pop per cycle
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++)
        if (2'(i) < res_n) q_mem[q_wr + QAW'(i)] <= res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (take) q_wr <= q_wr + QAW'(res_n);
      if (pop)  q_rd <= q_rd + 1'b1;
      q_cnt <= q_cnt + (take ? (QAW+1)'(res_n) : '0) - (pop ? (QAW+1)'(1) : '0);
    end
  end

  assign tok.valid         = (q_cnt != '0);
  assign tok.kind          = q_mem[q_rd].kind;
  assign tok.start_offset  = q_mem[q_rd].start_offset;
  assign tok.lexeme_length = q_mem[q_rd].lexeme_length;
  assign tok.line_number   = q_mem[q_rd].line_number;
  assign tok.last          = q_mem[q_rd].last;

endmodule
